@@ hw/rtl/mqus_pkg.sv @@
package mqus_pkg;

	localparam int SLOTS_PER_BUFFER = 8;
	localparam int NUM_BUFFERS      = 4;
	localparam int PAYLOAD_BITS     = 64;

	localparam int SLOT_W    = $clog2(SLOTS_PER_BUFFER);
	localparam int FILL_W    = $clog2(SLOTS_PER_BUFFER + 1);
	localparam int SUM_W     = FILL_W + 1;
	localparam int BUF_W     = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int MEM_DEPTH = NUM_BUFFERS * SLOTS_PER_BUFFER;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_URGENT = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BCAST,
		S_READ,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                    we;
		logic                    re;
		logic [ADDR_W-1:0]       addr;
		logic [PAYLOAD_BITS-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		status_t                 status;
		logic                    urgent;
		logic [PAYLOAD_BITS-1:0] word;
	} result_t;

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] pos);
		logic [SLOT_W-1:0] nxt;
		if (32'(pos) == SLOTS_PER_BUFFER - 1)
			nxt = '0;
		else
			nxt = pos + SLOT_W'(1);
		return nxt;
	endfunction

	// physical slot of a logical stack position, stack kept as a circular window
	function automatic logic [SLOT_W-1:0] urgent_slot(input logic [SLOT_W-1:0] base,
		input logic [FILL_W-1:0] offset);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(offset);
		if (32'(sum) >= SLOTS_PER_BUFFER)
			sum = sum - SUM_W'(SLOTS_PER_BUFFER);
		return SLOT_W'(sum);
	endfunction

	function automatic logic [ADDR_W-1:0] mem_addr(input logic [BUF_W-1:0] buf_sel,
		input logic [SLOT_W-1:0] slot);
		return ADDR_W'(buf_sel) * ADDR_W'(SLOTS_PER_BUFFER) + ADDR_W'(slot);
	endfunction

endpackage

@@ hw/rtl/mailbox_queue_with_urgent_stack.sv @@
// Mailbox with four buffers, each holding an eight-word FIFO ring and an eight-word urgent
// stack; all words sit in two single-port synchronous RAMs (ring and urgent), pointers and
// fill counts in flops. An input word on s_* carries the operation and buffer in s_tuser and
// the message in s_tdata; every word produces exactly one result word on m_* with the status
// and urgent flag in m_tuser and the removed message (zero unless a remove succeeded) in
// m_tdata. One item is worked at a time: a normal insert writes the ring RAM directly, a remove
// adds one RAM read before the result, and an urgent broadcast pushes the word into every stack,
// since the push walks the buffers one per cycle through the urgent RAM's single write port. The
// result register lets the next item be accepted while the previous result is still waiting on m_tready.
module mailbox_queue_with_urgent_stack
	import mqus_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // payload
	input  logic [3:0]  s_tuser,  // operation [1:0], buffer_index [3:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // removed_payload
	output logic [2:0]  m_tuser   // status [1:0], was_urgent [2]
);

	mem_req_t                ring_req, urg_req;
	logic [PAYLOAD_BITS-1:0] ring_rdata, urg_rdata;
	result_t                 res;

	mqus_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser[1:0]),
		.in_buf     (s_tuser[3:2]),
		.in_word    (s_tdata[PAYLOAD_BITS-1:0]),
		.ring_req   (ring_req),
		.ring_rdata (ring_rdata),
		.urg_req    (urg_req),
		.urg_rdata  (urg_rdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (res)
	);

	mqus_ram #(
		.DEPTH (MEM_DEPTH),
		.WIDTH (PAYLOAD_BITS)
	) u_ring_ram (
		.clk   (clk),
		.we    (ring_req.we),
		.re    (ring_req.re),
		.addr  (ring_req.addr),
		.wdata (ring_req.wdata),
		.rdata (ring_rdata)
	);

	mqus_ram #(
		.DEPTH (MEM_DEPTH),
		.WIDTH (PAYLOAD_BITS)
	) u_urg_ram (
		.clk   (clk),
		.we    (urg_req.we),
		.re    (urg_req.re),
		.addr  (urg_req.addr),
		.wdata (urg_req.wdata),
		.rdata (urg_rdata)
	);

	assign m_tdata = 64'(res.word);
	assign m_tuser = {res.urgent, res.status};

endmodule

@@ hw/rtl/mqus_ram.sv @@
module mqus_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		if (re)
			rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/mqus_ctrl.sv @@
module mqus_ctrl
	import mqus_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              in_op,
	input  logic [1:0]              in_buf,
	input  logic [PAYLOAD_BITS-1:0] in_word,
	output mem_req_t                ring_req,
	input  logic [PAYLOAD_BITS-1:0] ring_rdata,
	output mem_req_t                urg_req,
	input  logic [PAYLOAD_BITS-1:0] urg_rdata,
	output logic                    out_valid,
	input  logic                    out_ready,
	output result_t                 out_res
);

	state_t state_q, state_d;

	logic [BUF_W-1:0]        idx_q;
	logic [PAYLOAD_BITS-1:0] word_q;
	logic                    src_urg_q;
	result_t                 res_q;
	logic                    out_valid_q;
	result_t                 out_res_q;

	logic [SLOT_W-1:0] ring_head_q [NUM_BUFFERS];
	logic [SLOT_W-1:0] ring_tail_q [NUM_BUFFERS];
	logic [FILL_W-1:0] ring_fill_q [NUM_BUFFERS];
	logic [SLOT_W-1:0] urg_base_q  [NUM_BUFFERS];
	logic [FILL_W-1:0] urg_fill_q  [NUM_BUFFERS];

	logic [BUF_W-1:0]  sel;
	logic              buf_ok;
	logic [SLOT_W-1:0] r_head, r_tail, u_base;
	logic [FILL_W-1:0] r_fill, u_fill;

	logic    ring_push, ring_pop, urg_push, urg_pop;
	logic    res_load, src_urg_d, out_load, idx_clr, idx_inc, word_load;
	result_t res_d;

	// one pointer set is touched per cycle: the broadcast walks idx_q, else the item's buffer
	assign sel    = (state_q == S_BCAST) ? idx_q : BUF_W'(in_buf);
	assign buf_ok = 32'(in_buf) < NUM_BUFFERS;
	assign r_head = ring_head_q[sel];
	assign r_tail = ring_tail_q[sel];
	assign r_fill = ring_fill_q[sel];
	assign u_base = urg_base_q[sel];
	assign u_fill = urg_fill_q[sel];

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ring_req  = '0;
		urg_req   = '0;
		ring_push = 1'b0;
		ring_pop  = 1'b0;
		urg_push  = 1'b0;
		urg_pop   = 1'b0;
		res_load  = 1'b0;
		res_d     = res_q;
		src_urg_d = src_urg_q;
		out_load  = 1'b0;
		idx_clr   = 1'b0;
		idx_inc   = 1'b0;
		word_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					res_load     = 1'b1;
					res_d.status = STAT_DONE;
					res_d.urgent = 1'b0;
					res_d.word   = '0;
					state_d      = S_DONE;
					case (in_op)
						OP_INSERT: begin
							if (buf_ok && (32'(r_fill) < SLOTS_PER_BUFFER)) begin
								ring_req.we    = 1'b1;
								ring_req.addr  = mem_addr(sel, r_tail);
								ring_req.wdata = in_word;
								ring_push      = 1'b1;
							end else begin
								res_d.status = STAT_FULL;
							end
						end
						OP_URGENT: begin
							word_load = 1'b1;
							idx_clr   = 1'b1;
							state_d   = S_BCAST;
						end
						OP_REMOVE: begin
							if (!buf_ok) begin
								res_d.status = STAT_EMPTY;
							end else if (u_fill != '0) begin
								urg_req.re   = 1'b1;
								urg_req.addr = mem_addr(sel,
									urgent_slot(u_base, u_fill - FILL_W'(1)));
								urg_pop      = 1'b1;
								src_urg_d    = 1'b1;
								state_d      = S_READ;
							end else if (r_fill != '0) begin
								ring_req.re   = 1'b1;
								ring_req.addr = mem_addr(sel, r_head);
								ring_pop      = 1'b1;
								src_urg_d     = 1'b0;
								state_d       = S_READ;
							end else begin
								res_d.status = STAT_EMPTY;
							end
						end
						default: begin
							res_d.status = STAT_DONE;
						end
					endcase
				end
			end
			S_BCAST: begin
				urg_req.we    = 1'b1;
				urg_req.addr  = mem_addr(sel, urgent_slot(u_base, u_fill));
				urg_req.wdata = word_q;
				urg_push      = 1'b1;
				idx_inc       = 1'b1;
				if (32'(idx_q) == NUM_BUFFERS - 1)
					state_d = S_DONE;
			end
			S_READ: begin
				res_load     = 1'b1;
				res_d.urgent = src_urg_q;
				res_d.word   = src_urg_q ? urg_rdata : ring_rdata;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			src_urg_q   <= 1'b0;
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				ring_head_q[i] <= '0;
				ring_tail_q[i] <= '0;
				ring_fill_q[i] <= '0;
				urg_base_q[i]  <= '0;
				urg_fill_q[i]  <= '0;
			end
		end else begin
			state_q   <= state_d;
			src_urg_q <= src_urg_d;
			if (idx_clr)
				idx_q <= '0;
			else if (idx_inc)
				idx_q <= idx_q + BUF_W'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (ring_push) begin
				ring_tail_q[sel] <= slot_next(r_tail);
				ring_fill_q[sel] <= r_fill + FILL_W'(1);
			end
			if (ring_pop) begin
				ring_head_q[sel] <= slot_next(r_head);
				ring_fill_q[sel] <= r_fill - FILL_W'(1);
			end
			if (urg_push) begin
				// full stack drops its oldest word by sliding the window base
				if (32'(u_fill) >= SLOTS_PER_BUFFER)
					urg_base_q[sel] <= slot_next(u_base);
				else
					urg_fill_q[sel] <= u_fill + FILL_W'(1);
			end
			if (urg_pop)
				urg_fill_q[sel] <= u_fill - FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (word_load)
			word_q <= in_word;
		if (res_load)
			res_q <= res_d;
		if (out_load)
			out_res_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

@@ hw/rtl/mqus_checker.sv @@
module mqus_checker
	import mqus_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic [3:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// a result word waiting for the sink must not change
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// one item at a time: the block is busy right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[1:0] == STAT_DONE) || (m_tuser[1:0] == STAT_FULL)
			|| (m_tuser[1:0] == STAT_EMPTY))
		else $error("undefined status code");

	// a failed operation returns no word
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != STAT_DONE) |-> (m_tdata == 64'd0) && !m_tuser[2])
		else $error("word or urgent flag on a failed operation");

	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(arst_n) |-> !m_tvalid)
		else $error("result valid out of reset");

endmodule

bind mailbox_queue_with_urgent_stack mqus_checker u_mqus_checker (.*);
